[design/csmm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the complex square matrix multiply block.
// Used by csmm_mac and the top level; depends on nothing.
package csmm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;

  localparam int IDX_BITS  = 3;
  localparam int REG_BITS  = 3;
  localparam int SIZE_BITS = 4;

  localparam logic [REG_BITS-1:0] REG_MATRIX_SIZE = 3'd0;
  localparam logic [REG_BITS-1:0] REG_SWAP        = 3'd1;
  localparam logic [REG_BITS-1:0] REG_ALPHA_RE    = 3'd2;
  localparam logic [REG_BITS-1:0] REG_ALPHA_IM    = 3'd3;
  localparam logic [REG_BITS-1:0] REG_BETA_RE     = 3'd4;
  localparam logic [REG_BITS-1:0] REG_BETA_IM     = 3'd5;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ALPHA,
    S_BETA,
    S_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ACC_SR,
    ACC_SI,
    ACC_TR,
    ACC_TI
  } acc_sel_t;

  // One request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic     valid;
    acc_sel_t tgt;
    logic     sub;
    logic     shl;
  } mac_ctl_t;

endpackage

[design/csmm_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module csmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/csmm_mac.sv]
`timescale 1ns / 1ps
// Shared multiplier with a product register and four accumulators.
// Depends on csmm_pkg for the request struct and accumulator codes.
module csmm_mac import csmm_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int SUM_BITS  = 2 * ELEM_BITS_DEF + 4,
  parameter int TOT_BITS  = 3 * ELEM_BITS_DEF + 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  mac_ctl_t                    ctl,
  input  logic signed [ELEM_BITS-1:0] op_a,
  input  logic signed [SUM_BITS-1:0]  op_b,
  output logic signed [SUM_BITS-1:0]  sr,
  output logic signed [SUM_BITS-1:0]  si,
  output logic signed [TOT_BITS-1:0]  tr,
  output logic signed [TOT_BITS-1:0]  ti
);

  localparam int PROD_BITS = ELEM_BITS + SUM_BITS;
  localparam int FRAC      = ELEM_BITS - 1;

  logic signed [PROD_BITS-1:0] prod;
  mac_ctl_t                    ctl_q;
  logic signed [TOT_BITS-1:0]  term;
  logic signed [SUM_BITS-1:0]  sterm;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
    prod <= op_a * op_b;
  end

  // Scaled terms such as beta times C are lifted to the alpha product's scale.
  always_comb begin
    term  = ctl_q.shl ? (TOT_BITS'(prod) <<< FRAC) : TOT_BITS'(prod);
    sterm = SUM_BITS'(prod);
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      sr <= '0;
      si <= '0;
      tr <= '0;
      ti <= '0;
    end else if (ctl_q.valid) begin
      case (ctl_q.tgt)
        ACC_SR: sr <= ctl_q.sub ? sr - sterm : sr + sterm;
        ACC_SI: si <= ctl_q.sub ? si - sterm : si + sterm;
        ACC_TR: tr <= ctl_q.sub ? tr - term : tr + term;
        ACC_TI: ti <= ctl_q.sub ? ti - term : ti + term;
        default: ;
      endcase
    end
  end

endmodule

[design/complex_square_matrix_multiply.sv]
`timescale 1ns / 1ps
// Top level of the complex square matrix multiply: sequencer, stores, output.
// Depends on csmm_pkg, csmm_ram and csmm_mac.
//
// Load items (op 0, 1, 2) write one element of A, B or C and never raise
// busy, so loads may arrive every cycle while busy is low. A compute item
// raises busy and emits N*N results in column-major order, one strobe cycle
// each, the last one flagged; every result is also written back into C. All
// complex products go through one shared multiplier, four real multiplies
// per complex product. Results cannot be held off by the receiver. Entries
// read by a compute must have been loaded first.
module complex_square_matrix_multiply import csmm_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [IDX_BITS-1:0]         row,
  input  logic [IDX_BITS-1:0]         col,
  input  logic signed [ELEM_BITS-1:0] elem_re,
  input  logic signed [ELEM_BITS-1:0] elem_im,
  input  logic                        cfg_we,
  input  logic [REG_BITS-1:0]         cfg_index,
  input  logic [ELEM_BITS-1:0]        cfg_data,
  output logic                        out_valid,
  output logic [IDX_BITS-1:0]         out_row,
  output logic [IDX_BITS-1:0]         out_col,
  output logic signed [ELEM_BITS-1:0] res_re,
  output logic signed [ELEM_BITS-1:0] res_im,
  output logic                        saturated,
  output logic                        last
);

  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int AW       = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int IW       = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
  localparam int SUM_BITS = 2 * ELEM_BITS + 4;
  localparam int TOT_BITS = 3 * ELEM_BITS + 5;
  localparam int FRAC     = ELEM_BITS - 1;
  localparam int RND_BITS = TOT_BITS - 2 * FRAC;
  localparam int WW       = 2 * ELEM_BITS;

  localparam logic signed [ELEM_BITS-1:0] EMAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
  localparam logic signed [ELEM_BITS-1:0] EMIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
  localparam logic [IW-1:0] DIM_M1 = IW'(MAX_DIM - 1);

  // Configuration registers.
  logic [SIZE_BITS-1:0]        matrix_size;
  logic                        swap_operands;
  logic signed [ELEM_BITS-1:0] alpha_re, alpha_im, beta_re, beta_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size   <= SIZE_RESET;
      swap_operands <= 1'b0;
      alpha_re      <= EMAX;
      alpha_im      <= '0;
      beta_re       <= '0;
      beta_im       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATRIX_SIZE: matrix_size   <= cfg_data[SIZE_BITS-1:0];
        REG_SWAP:        swap_operands <= cfg_data[0];
        REG_ALPHA_RE:    alpha_re      <= cfg_data;
        REG_ALPHA_IM:    alpha_im      <= cfg_data;
        REG_BETA_RE:     beta_re       <= cfg_data;
        REG_BETA_IM:     beta_im       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and loop counters.
  state_t        state, state_next;
  logic [1:0]    step;
  logic [IW-1:0] i, j, k, nm1;

  logic accept, compute_go, load_go, elem_done, run_done;

  assign accept     = start && !busy;
  assign compute_go = accept && (op_t'(op) == OP_COMPUTE);
  assign load_go    = accept && (op_t'(op) != OP_COMPUTE) &&
                      (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign elem_done  = (i == nm1);
  assign run_done   = (i == nm1) && (j == nm1);
  assign busy       = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (compute_go) state_next = S_RD;
      S_RD:    state_next = S_MUL;
      S_MUL:   if (step == 2'd3) state_next = (k == nm1) ? S_ALPHA : S_RD;
      S_ALPHA: if (step == 2'd3) state_next = S_BETA;
      S_BETA:  if (step == 2'd3) state_next = S_FIN;
      S_FIN:   state_next = S_EMIT;
      S_EMIT:  state_next = run_done ? S_IDLE : S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      nm1   <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL || state == S_ALPHA || state == S_BETA) begin
        step <= step + 2'd1;
      end else begin
        step <= '0;
      end
      if (compute_go) begin
        i <= '0;
        j <= '0;
        k <= '0;
        if (matrix_size == '0) begin
          nm1 <= '0;
        end else if (int'(matrix_size) > MAX_DIM) begin
          nm1 <= DIM_M1;
        end else begin
          nm1 <= IW'(matrix_size - 4'd1);
        end
      end else if (state == S_MUL && step == 2'd3 && k != nm1) begin
        k <= k + IW'(1);
      end else if (state == S_EMIT) begin
        k <= '0;
        if (elem_done) begin
          i <= '0;
          j <= j + IW'(1);
        end else begin
          i <= i + IW'(1);
        end
      end
    end
  end

  // Element stores: {re, im} per entry, row-major with a stride of MAX_DIM.
  logic [AW-1:0] ld_addr, p_addr, q_addr, c_addr;
  logic          a_we, b_we, c_we, ab_re, c_re_en;
  logic [WW-1:0] a_q, b_q, c_q, c_wdata;
  logic [AW-1:0] a_raddr, b_raddr, c_waddr;

  assign ld_addr = AW'(int'(row) * MAX_DIM + int'(col));
  assign p_addr  = AW'(int'(i) * MAX_DIM + int'(k));
  assign q_addr  = AW'(int'(k) * MAX_DIM + int'(j));
  assign c_addr  = AW'(int'(i) * MAX_DIM + int'(j));

  // With the operands swapped, B supplies the row operand and A the column one.
  assign a_raddr = swap_operands ? q_addr : p_addr;
  assign b_raddr = swap_operands ? p_addr : q_addr;

  logic signed [ELEM_BITS-1:0] rr_sat, ri_sat;
  logic                        clip_re, clip_im;

  assign a_we    = load_go && (op_t'(op) == OP_LOAD_A);
  assign b_we    = load_go && (op_t'(op) == OP_LOAD_B);
  assign c_we    = (load_go && (op_t'(op) == OP_LOAD_C)) || (state == S_EMIT);
  assign c_waddr = (state == S_EMIT) ? c_addr : ld_addr;
  assign c_wdata = (state == S_EMIT) ? {rr_sat, ri_sat} : {elem_re, elem_im};

  csmm_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_a_store (
    .clk, .we(a_we), .waddr(ld_addr), .wdata({elem_re, elem_im}),
    .re(ab_re), .raddr(a_raddr), .rdata(a_q)
  );

  csmm_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_b_store (
    .clk, .we(b_we), .waddr(ld_addr), .wdata({elem_re, elem_im}),
    .re(ab_re), .raddr(b_raddr), .rdata(b_q)
  );

  csmm_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_c_store (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re_en), .raddr(c_addr), .rdata(c_q)
  );

  // Operand selection for the shared multiplier.
  logic [WW-1:0]               x_q, y_q;
  logic signed [ELEM_BITS-1:0] xr, xi, yr, yi, cr, ci;
  logic signed [SUM_BITS-1:0]  sr, si;
  logic signed [TOT_BITS-1:0]  tr, ti;
  mac_ctl_t                    mctl;
  logic signed [ELEM_BITS-1:0] op_a;
  logic signed [SUM_BITS-1:0]  op_b;
  logic                        clr;

  assign x_q = swap_operands ? b_q : a_q;
  assign y_q = swap_operands ? a_q : b_q;
  assign xr  = x_q[WW-1:ELEM_BITS];
  assign xi  = x_q[ELEM_BITS-1:0];
  assign yr  = y_q[WW-1:ELEM_BITS];
  assign yi  = y_q[ELEM_BITS-1:0];
  assign cr  = c_q[WW-1:ELEM_BITS];
  assign ci  = c_q[ELEM_BITS-1:0];

  always_comb begin
    mctl    = '0;
    op_a    = '0;
    op_b    = '0;
    ab_re   = (state == S_RD);
    c_re_en = (state == S_ALPHA) && (step == 2'd0);
    clr     = compute_go || (state == S_EMIT);
    case (state)
      S_MUL: begin
        mctl.valid = 1'b1;
        case (step)
          2'd0: begin op_a = xr; op_b = SUM_BITS'(yr); mctl.tgt = ACC_SR; end
          2'd1: begin op_a = xi; op_b = SUM_BITS'(yi); mctl.tgt = ACC_SR;
                      mctl.sub = 1'b1; end
          2'd2: begin op_a = xr; op_b = SUM_BITS'(yi); mctl.tgt = ACC_SI; end
          default: begin op_a = xi; op_b = SUM_BITS'(yr); mctl.tgt = ACC_SI; end
        endcase
      end
      S_ALPHA: begin
        mctl.valid = 1'b1;
        case (step)
          2'd0: begin op_a = alpha_re; op_b = sr; mctl.tgt = ACC_TR; end
          2'd1: begin op_a = alpha_im; op_b = si; mctl.tgt = ACC_TR;
                      mctl.sub = 1'b1; end
          2'd2: begin op_a = alpha_re; op_b = si; mctl.tgt = ACC_TI; end
          default: begin op_a = alpha_im; op_b = sr; mctl.tgt = ACC_TI; end
        endcase
      end
      S_BETA: begin
        mctl.valid = 1'b1;
        mctl.shl   = 1'b1;
        case (step)
          2'd0: begin op_a = beta_re; op_b = SUM_BITS'(cr); mctl.tgt = ACC_TR; end
          2'd1: begin op_a = beta_im; op_b = SUM_BITS'(ci); mctl.tgt = ACC_TR;
                      mctl.sub = 1'b1; end
          2'd2: begin op_a = beta_re; op_b = SUM_BITS'(ci); mctl.tgt = ACC_TI; end
          default: begin op_a = beta_im; op_b = SUM_BITS'(cr); mctl.tgt = ACC_TI; end
        endcase
      end
      default: ;
    endcase
  end

  csmm_mac #(
    .ELEM_BITS(ELEM_BITS), .SUM_BITS(SUM_BITS), .TOT_BITS(TOT_BITS)
  ) u_mac (
    .clk, .rst, .clr, .ctl(mctl), .op_a, .op_b, .sr, .si, .tr, .ti
  );

  // Round half up by adding half an LSB and shifting arithmetically, then clip.
  logic signed [TOT_BITS-1:0] tr_rnd, ti_rnd;
  logic signed [RND_BITS-1:0] rr_full, ri_full;

  always_comb begin
    tr_rnd  = tr + (TOT_BITS'(1) <<< (2 * FRAC - 1));
    ti_rnd  = ti + (TOT_BITS'(1) <<< (2 * FRAC - 1));
    rr_full = RND_BITS'(tr_rnd >>> (2 * FRAC));
    ri_full = RND_BITS'(ti_rnd >>> (2 * FRAC));
    clip_re = 1'b0;
    clip_im = 1'b0;
    rr_sat  = ELEM_BITS'(rr_full);
    ri_sat  = ELEM_BITS'(ri_full);
    if (rr_full > RND_BITS'(EMAX)) begin
      rr_sat  = EMAX;
      clip_re = 1'b1;
    end else if (rr_full < RND_BITS'(EMIN)) begin
      rr_sat  = EMIN;
      clip_re = 1'b1;
    end
    if (ri_full > RND_BITS'(EMAX)) begin
      ri_sat  = EMAX;
      clip_im = 1'b1;
    end else if (ri_full < RND_BITS'(EMIN)) begin
      ri_sat  = EMIN;
      clip_im = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_EMIT);
    end
    if (state == S_EMIT) begin
      out_row   <= IDX_BITS'(i);
      out_col   <= IDX_BITS'(j);
      res_re    <= rr_sat;
      res_im    <= ri_sat;
      saturated <= clip_re || clip_im;
      last      <= run_done;
    end
  end

  // A result only follows the emit step of the sequencer.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(state == S_EMIT))
    else $error("result strobe without an emit step");

  // The block goes idle only together with the final result of a run.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (out_valid && last))
    else $error("compute ended without a final result");

  // Loop counters stay inside the active square.
  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (i <= nm1 && j <= nm1 && k <= nm1))
    else $error("loop counter outside the matrix");

  // Results are spaced by a full element pass, never back to back.
  a_result_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

endmodule
